[sv/cba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cba_pkg: shared definitions of the contiguous block allocator
// Widths, command and status codes, and register offsets.
// ----------------------------------------------------------------------------
package cba_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	localparam int LEN_W   = 9;
	localparam int FIRST_W = 8;
	localparam int START_W = 8;
	localparam int STAT_W  = 2;
	localparam int FREE_W  = 9;
	localparam int CFG_W   = 9;

	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int SUM_W = CMP_W + 1;

	localparam int S_DATA_W = ((LEN_W + FIRST_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((STAT_W + START_W + FREE_W + 7) / 8) * 8;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam int REG_BLOCKS_IN_USE = 0;
	localparam int BLOCKS_RESET      = 256;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_RUN = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

endpackage
`default_nettype wire

[sv/cba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cba_ram: generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module cba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[sv/contiguous_block_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_block_allocator_core: first-fit contiguous block allocator
// Keeps a one-bit-per-block free map and serves allocate and free requests.
// ----------------------------------------------------------------------------
// After reset the block sets every map entry to free, and takes no request
// during that pass. The map lives in a one-bit RAM that is read or written
// once per cycle, and that port sets the timing. An allocate scans the map
// for a free run and marks it when it finds one; a free marks its range when
// that lies within the blocks in use. Either then counts the used blocks
// before the result is handed over. One request is worked on at a time; a
// finished result waits in the output register.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Request stream.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// run_length [8:0], first_block [16:9], zero fill above
	input  wire logic [cba_pkg::S_DATA_W-1:0]      s_tdata,
	// cmd [0]
	input  wire logic                              s_tuser,
	// Result stream.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// status [1:0], granted_start [9:2], free_blocks [18:10], zero fill above
	output logic      [cba_pkg::M_DATA_W-1:0]      m_tdata,
	// Configuration port.
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [cba_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [cba_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [cba_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready
);

	import cba_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MARK  = 3'd3;
	localparam logic [2:0] S_COUNT = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   end_q;
	logic [CNT_W-1:0]   ev_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CMP_W-1:0]   run_q;
	logic [CMP_W-1:0]   start_q;
	logic [LEN_W-1:0]   len_q;
	logic               cmd_q;
	logic               wr_val_q;
	logic               rvalid_q;
	logic [STAT_W-1:0]  status_q;
	logic [CFG_W-1:0]   blocks_q;

	logic               m_tvalid_q;
	logic [STAT_W-1:0]  m_status_q;
	logic [START_W-1:0] m_start_q;
	logic [FREE_W-1:0]  m_free_q;

	logic [CMP_W-1:0]   n_c;
	logic [CMP_W-1:0]   cfg_ext_c;
	logic               issue_c;
	logic [CMP_W-1:0]   run_inc_c;
	logic [CMP_W-1:0]   start_c;
	logic [LEN_W-1:0]   s_len_c;
	logic [FIRST_W-1:0] s_first_c;
	logic [SUM_W-1:0]   sum_c;
	logic               cfg_wr_c;
	logic               ram_we_c;
	logic               ram_wdata_c;
	logic               ram_rdata;
	logic               load_c;

	// Blocks in use, capped at the size of the map.
	assign cfg_ext_c = CMP_W'(blocks_q);
	assign n_c = (cfg_ext_c > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : cfg_ext_c;

	assign issue_c   = CMP_W'(pos_q) < n_c;
	assign run_inc_c = run_q + CMP_W'(1);
	assign start_c   = CMP_W'(ev_q) + CMP_W'(1) - CMP_W'(len_q);

	assign s_len_c   = s_tdata[LEN_W-1:0];
	assign s_first_c = s_tdata[LEN_W+FIRST_W-1:LEN_W];
	assign sum_c     = SUM_W'(s_first_c) + SUM_W'(s_len_c);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W - STAT_W - START_W - FREE_W){1'b0}},
	                   m_free_q, m_start_q, m_status_q};

	// The finished result moves into the output register once that is free or its result is taken.
	assign load_c = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// Map RAM: one means free.
	assign ram_we_c    = (state_q == S_CLEAR) || (state_q == S_MARK);
	assign ram_wdata_c = (state_q == S_CLEAR) || wr_val_q;

	cba_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BLOCKS)
	) u_map (
		.clk  (clk),
		.we   (ram_we_c),
		.waddr(pos_q[IDX_W-1:0]),
		.wdata(ram_wdata_c),
		.raddr(pos_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// Configuration register.
	assign pready   = 1'b1;
	assign cfg_wr_c = psel && penable && pwrite && pready
	                  && (paddr[APB_ADDR_W-1:2] == 1'(REG_BLOCKS_IN_USE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q <= CFG_W'(BLOCKS_RESET);
		end else if (cfg_wr_c) begin
			blocks_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1:2] == 1'(REG_BLOCKS_IN_USE)) begin
			prdata[CFG_W-1:0] = blocks_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_status_q <= STAT_OK;
			m_start_q  <= '0;
			m_free_q   <= '0;
		end else if (load_c) begin
			m_tvalid_q <= 1'b1;
			m_status_q <= status_q;
			m_start_q  <= ((status_q == STAT_OK) && (cmd_q == CMD_ALLOC))
			              ? start_q[START_W-1:0] : '0;
			m_free_q   <= FREE_W'(n_c - CMP_W'(cnt_q));
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			pos_q      <= '0;
			rvalid_q   <= 1'b0;
		end else begin
			rvalid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (pos_q == CNT_W'(MAX_BLOCKS - 1)) begin
						pos_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tuser;
						len_q <= s_len_c;
						run_q <= '0;
						cnt_q <= '0;
						if (s_tuser == CMD_ALLOC) begin
							wr_val_q <= 1'b0;
							if ((s_len_c == '0) || (n_c == '0)) begin
								status_q <= STAT_NO_RUN;
								pos_q    <= '0;
								state_q  <= S_COUNT;
							end else begin
								pos_q   <= '0;
								state_q <= S_SCAN;
							end
						end else begin
							wr_val_q <= 1'b1;
							if (sum_c > SUM_W'(n_c)) begin
								status_q <= STAT_RANGE;
								pos_q    <= '0;
								state_q  <= S_COUNT;
							end else if (s_len_c == '0) begin
								status_q <= STAT_OK;
								pos_q    <= '0;
								state_q  <= S_COUNT;
							end else begin
								status_q <= STAT_OK;
								pos_q    <= CNT_W'(s_first_c);
								end_q    <= CNT_W'(sum_c - SUM_W'(1));
								state_q  <= S_MARK;
							end
						end
					end
				end
				S_SCAN: begin
					// Reads are issued one ahead of the evaluation of their data.
					if (issue_c) begin
						rvalid_q <= 1'b1;
						ev_q     <= pos_q;
						pos_q    <= pos_q + CNT_W'(1);
					end
					if (rvalid_q) begin
						if (ram_rdata) begin
							if (run_inc_c == CMP_W'(len_q)) begin
								start_q  <= start_c;
								pos_q    <= start_c[CNT_W-1:0];
								end_q    <= ev_q;
								status_q <= STAT_OK;
								rvalid_q <= 1'b0;
								state_q  <= S_MARK;
							end else begin
								run_q <= run_inc_c;
							end
						end else begin
							run_q <= '0;
						end
					end else if (!issue_c) begin
						status_q <= STAT_NO_RUN;
						pos_q    <= '0;
						state_q  <= S_COUNT;
					end
				end
				S_MARK: begin
					if (pos_q == end_q) begin
						pos_q   <= '0;
						state_q <= S_COUNT;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
					end
				end
				S_COUNT: begin
					if (issue_c) begin
						rvalid_q <= 1'b1;
						pos_q    <= pos_q + CNT_W'(1);
					end
					if (rvalid_q) begin
						if (!ram_rdata) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end else if (!issue_c) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_c) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result never carries the unused status code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3))
		else $error("result carries an undefined status code");

	// A failed request names no start block.
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] != STAT_OK)) |-> (m_tdata[9:2] == '0))
		else $error("failed request reports a start block");

	// The marking pass never runs past the end of its range.
	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (pos_q <= end_q))
		else $error("marking pass overran its range");

	// A new result appears only when the sequencer hands it over.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the hand-over state");

	// The free count never exceeds the size of the map.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[18:10] <= FREE_W'(MAX_BLOCKS)))
		else $error("free count exceeds the map size");

endmodule
`default_nettype wire

[bench/contiguous_block_allocator_core_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_block_allocator_core_tb: self-checking bench of the allocator
// A directed table and several random phases, each phase under its own count
// of blocks in use, drive allocate and free requests. Every result is compared
// with the typed row or a first-fit prediction over a private free map copy.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_core_tb;

	import cba_pkg::*;

	typedef struct packed {
		logic               cmd;
		logic [LEN_W-1:0]   len;
		logic [FIRST_W-1:0] first;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [START_W-1:0] granted;
		logic [FREE_W-1:0]  free_cnt;
	} outcome_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		outcome_t want;
	} row_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} run_t;

	localparam int NUM_DIRECTED    = 21;
	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int PRESSURE_PHASE  = 4;
	localparam int STEADY_PHASE    = 8;
	localparam int HOLD_CYCLES     = 3000;

	// Extremes early on: none in use, above the cap, a single block.
	localparam int PHASE_BLOCKS [NUM_PHASES] = '{8, 0, 511, 1, 256, 300, 16, 3, 64, 256};

	// The table starts from an all-free map of 256 blocks and runs in order.
	localparam row_t DIRECTED [NUM_DIRECTED] = '{
		'{'{CMD_ALLOC, 9'd0,   8'd0},   1'b1, '{STAT_NO_RUN, 8'd0, 9'd256}},
		'{'{CMD_ALLOC, 9'd256, 8'd255}, 1'b1, '{STAT_OK,     8'd0, 9'd0}},
		'{'{CMD_ALLOC, 9'd1,   8'd0},   1'b1, '{STAT_NO_RUN, 8'd0, 9'd0}},
		'{'{CMD_FREE,  9'd1,   8'd255}, 1'b1, '{STAT_OK,     8'd0, 9'd1}},
		'{'{CMD_FREE,  9'd256, 8'd0},   1'b1, '{STAT_OK,     8'd0, 9'd256}},
		'{'{CMD_FREE,  9'd2,   8'd255}, 1'b1, '{STAT_RANGE,  8'd0, 9'd256}},
		'{'{CMD_FREE,  9'd511, 8'd0},   1'b1, '{STAT_RANGE,  8'd0, 9'd256}},
		'{'{CMD_ALLOC, 9'd257, 8'd0},   1'b1, '{STAT_NO_RUN, 8'd0, 9'd256}},
		'{'{CMD_ALLOC, 9'd511, 8'd0},   1'b1, '{STAT_NO_RUN, 8'd0, 9'd256}},
		'{'{CMD_ALLOC, 9'd3,   8'd170}, 1'b1, '{STAT_OK,     8'd0, 9'd253}},
		'{'{CMD_ALLOC, 9'd5,   8'd0},   1'b1, '{STAT_OK,     8'd3, 9'd248}},
		'{'{CMD_FREE,  9'd1,   8'd1},   1'b1, '{STAT_OK,     8'd0, 9'd249}},
		'{'{CMD_ALLOC, 9'd2,   8'd0},   1'b0, '0},
		'{'{CMD_ALLOC, 9'd1,   8'd0},   1'b0, '0},
		'{'{CMD_FREE,  9'd0,   8'd0},   1'b0, '0},
		'{'{CMD_FREE,  9'd0,   8'd255}, 1'b0, '0},
		'{'{CMD_FREE,  9'd100, 8'd200}, 1'b0, '0},
		'{'{CMD_FREE,  9'd85,  8'd170}, 1'b0, '0},
		'{'{CMD_ALLOC, 9'd255, 8'd85},  1'b0, '0},
		'{'{CMD_FREE,  9'd256, 8'd0},   1'b1, '{STAT_OK,     8'd0, 9'd256}},
		'{'{CMD_ALLOC, 9'd128, 8'd0},   1'b1, '{STAT_OK,     8'd0, 9'd128}}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	// run_length [8:0], first_block [16:9], zero fill above
	logic [S_DATA_W-1:0]     s_tdata;
	// cmd [0]
	logic                    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	// status [1:0], granted_start [9:2], free_blocks [18:10], zero fill above
	logic [M_DATA_W-1:0]     m_tdata;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_ADDR_W-1:0]   paddr;
	logic [APB_DATA_W-1:0]   pwdata;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;

	bit                      block_free [MAX_BLOCKS];
	logic [CFG_W-1:0]        blocks_cfg;
	outcome_t                pending_results [$];
	run_t                    live_runs [$];
	int                      fail_count;
	int                      hold_left;
	bit                      steady;

	contiguous_block_allocator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int active_blocks();
		return (blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_cfg);
	endfunction

	// First-fit allocation over the private free map; also applies the request.
	function automatic outcome_t predict_outcome(request_t r);
		outcome_t o;
		int       n;
		int       run;
		int       used;
		int       s;
		bit       found;
		n = active_blocks();
		o.status  = STAT_NO_RUN;
		o.granted = '0;
		if (r.cmd == CMD_ALLOC) begin
			if (r.len != 0) begin
				run = 0;
				found = 1'b0;
				for (int i = 0; i < n && !found; i++) begin
					if (block_free[i]) begin
						run++;
						if (run == int'(r.len)) begin
							s = i + 1 - int'(r.len);
							for (int k = s; k <= i; k++)
								block_free[k] = 1'b0;
							o.granted = START_W'(s);
							o.status  = STAT_OK;
							found = 1'b1;
						end
					end else begin
						run = 0;
					end
				end
			end
		end else begin
			if (int'(r.first) + int'(r.len) > n) begin
				o.status = STAT_RANGE;
			end else begin
				for (int i = int'(r.first); i < int'(r.first) + int'(r.len); i++)
					block_free[i] = 1'b1;
				o.status = STAT_OK;
			end
		end
		used = 0;
		for (int i = 0; i < n; i++)
			if (!block_free[i])
				used++;
		o.free_cnt = FREE_W'(n - used);
		return o;
	endfunction

	// Mostly allocations of modest size and frees of runs still held, with
	// edge lengths and stray ranges mixed in.
	function automatic request_t random_request();
		request_t r;
		int       n;
		int       pick;
		int       lim;
		int       k;
		n = active_blocks();
		pick = $urandom_range(0, 99);
		r.first = FIRST_W'($urandom_range(0, 255));
		if (pick < 55) begin
			r.cmd = CMD_ALLOC;
			lim = (n / 4 > 1) ? n / 4 : 1;
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 4))
					0: begin
						r.len = '0;
					end
					1: begin
						r.len = LEN_W'(n);
					end
					2: begin
						r.len = LEN_W'(n + 1);
					end
					3: begin
						r.len = '1;
					end
					default: begin
						r.len = LEN_W'($urandom_range(0, 511));
					end
				endcase
			end else begin
				r.len = LEN_W'($urandom_range(1, lim));
			end
		end else if (pick < 85 && live_runs.size() > 0) begin
			k = $urandom_range(0, live_runs.size() - 1);
			r.cmd   = CMD_FREE;
			r.first = live_runs[k].start;
			r.len   = live_runs[k].len;
		end else begin
			r.cmd = CMD_FREE;
			case ($urandom_range(0, 3))
				0: begin
					r.first = '0;
					r.len   = '0;
				end
				1: begin
					// Range that ends exactly on the last block in use.
					if (n == 0) begin
						r.first = '0;
						r.len   = '0;
					end else begin
						r.len   = LEN_W'($urandom_range(1, n));
						r.first = FIRST_W'(n - int'(r.len));
					end
				end
				default: begin
					r.len = LEN_W'($urandom_range(0, (n > 16) ? n / 2 : 8));
				end
			endcase
		end
		return r;
	endfunction

	task automatic issue_request(input request_t r, input bit typed, input outcome_t want);
		outcome_t got;
		s_tvalid <= 1'b1;
		s_tuser  <= r.cmd;
		s_tdata  <= {{(S_DATA_W - LEN_W - FIRST_W){1'b0}}, r.first, r.len};
		do @(posedge clk); while (!s_tready);
		got = predict_outcome(r);
		pending_results.push_back(typed ? want : got);
		if (r.cmd == CMD_ALLOC && got.status == STAT_OK)
			live_runs.push_back('{got.granted, r.len});
		if (r.cmd == CMD_FREE && got.status == STAT_OK) begin
			for (int j = 0; j < live_runs.size(); j++) begin
				if (live_runs[j].start == r.first && live_runs[j].len == r.len) begin
					live_runs.delete(j);
					break;
				end
			end
		end
	endtask

	task automatic idle_sender(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if (!steady && $urandom_range(0, 99) < 16)
			idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(1, 600)
				: $urandom_range(1, 8));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_blocks_in_use(input int value);
		wait_drained();
		repeat (10) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(REG_BLOCKS_IN_USE * 4);
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		blocks_cfg = CFG_W'(value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Result side: random back-pressure, a steady phase, and one long hold.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending: m_tdata=%h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[STAT_W-1:0] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status,
						m_tdata[STAT_W-1:0]);
					fail_count++;
				end
				if (m_tdata[STAT_W +: START_W] !== want.granted) begin
					$error("granted_start: expected %0d, actual %0d", want.granted,
						m_tdata[STAT_W +: START_W]);
					fail_count++;
				end
				if (m_tdata[STAT_W + START_W +: FREE_W] !== want.free_cnt) begin
					$error("free_blocks: expected %0d, actual %0d", want.free_cnt,
						m_tdata[STAT_W + START_W +: FREE_W]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = CMD_ALLOC;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		fail_count = 0;
		hold_left  = 0;
		steady     = 1'b0;
		blocks_cfg = CFG_W'(BLOCKS_RESET);
		foreach (block_free[i])
			block_free[i] = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			maybe_idle();
			issue_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
		end

		// The map is kept across phases, so a smaller count leaves used blocks
		// beyond the new limit that must be neither scanned nor counted.
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_blocks_in_use(PHASE_BLOCKS[p]);
			steady = (p == STEADY_PHASE);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == PRESSURE_PHASE && i == 10)
					hold_left = HOLD_CYCLES;
				if (p == PRESSURE_PHASE && i == 30)
					wait_drained();
				maybe_idle();
				issue_request(random_request(), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (600) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
